// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // decoder mode, code 3 is unused and decodes as plain
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  typedef logic [7:0] byte_t;

  localparam int MAX_BYTES   = 6;
  localparam int NCNT_W      = 3;
  localparam int HELD_DEPTH  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_U     = 8'h75;
  localparam byte_t CH_N     = 8'h6E;
  localparam byte_t CH_R     = 8'h72;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;

  localparam logic [15:0] LIM_1BYTE = 16'h007F;
  localparam logic [15:0] LIM_2BYTE = 16'h07FF;
  localparam byte_t LEAD_2 = 8'hC0;
  localparam byte_t LEAD_3 = 8'hE0;
  localparam byte_t CONT   = 8'h80;

  // bytes of one decoded item, bytes[0] goes out first
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [NCNT_W-1:0]         n;
    logic                      last;
  } cmd_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input byte_t c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok = 1'b1;
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp <= LIM_1BYTE) begin
      u.bytes[0] = cp[7:0];
      u.n        = 2'd1;
    end else if (cp <= LIM_2BYTE) begin
      u.bytes[0] = LEAD_2 | {3'b000, cp[10:6]};
      u.bytes[1] = CONT | {2'b00, cp[5:0]};
      u.n        = 2'd2;
    end else begin
      u.bytes[0] = LEAD_3 | {4'b0000, cp[15:12]};
      u.bytes[1] = CONT | {2'b00, cp[11:6]};
      u.bytes[2] = CONT | {2'b00, cp[5:0]};
      u.n        = 2'd3;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// File: hdl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready byte stream channels of the unescaper, raw side and decoded side.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// File: hdl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper: raw bytes in, unescaped UTF-8 bytes out.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload        | handshake
//  in_ch    | in  | in_byte, in_last    | valid / ready
//  out_ch   | out | out_byte, out_last  | valid / ready
//
//  one raw byte is taken per cycle while the group queue has room
//  each raw byte yields zero to six output bytes, sent by the back end one per
//  cycle while out_ch is ready, so output bandwidth sets the sustained rate
//  a raw byte's output passes the group queue, then the output register
//  reset is synchronous, no clearing pass
//  a stalled output fills the QUEUE_DEPTH group queue, then input ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  cmd_t front_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_ready;
  logic q_valid;
  logic q_pop;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cmd     (front_cmd),
    .push    (q_push),
    .q_ready (q_ready)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (front_cmd),
    .wr_ready (q_ready),
    .rd_valid (q_valid),
    .rd_data  (q_head),
    .pop      (q_pop)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (q_head),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // a queued group always carries one to six bytes
  a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (front_cmd.n != '0) && (front_cmd.n <= NCNT_W'(MAX_BYTES)))
    else $error("empty or oversized byte group queued");

  // pending bytes with a free output stage must show a beat next cycle
  a_back_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && (!out_ch.valid || out_ch.ready)) |=> out_ch.valid)
    else $error("back end stalled with bytes pending");

  // a group leaves the queue only while the output stage can take a beat
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && (!out_ch.valid || out_ch.ready))
    else $error("group dropped without its last beat");

endmodule

`default_nettype wire

// File: hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Takes raw bytes, tracks escape state and turns each byte into a group of
// up to six output bytes for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  jsu_in_if.sink            in_ch,
  output jsu_pkg::cmd_t     cmd,
  output logic              push,
  input  wire logic         q_ready
);
  import jsu_pkg::*;

  mode_t           mode_r, mode_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [15:0]     cp_r, cp_nxt;
  logic [HELD_DEPTH-1:0][7:0] held_r, held_nxt;

  logic            accept;
  byte_t           c;
  logic            last;
  hex_t            hv;
  logic [15:0]     cp_shift;
  logic            new_esc;
  logic [NCNT_W-1:0] pos;
  utf8_t           u;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign c           = in_ch.in_byte;
  assign last        = in_ch.in_last;
  assign hv          = hex_decode(c);
  assign cp_shift    = {cp_r[11:0], hv.val};
  assign u           = utf8_encode(cp_shift);
  // a backslash opens a new escape unless it is the final byte
  assign new_esc     = (c == CH_BSL) && !last;
  assign pos         = {1'b0, cnt_r} + NCNT_W'(2);
  assign push        = accept && (cmd.n != '0);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      unique case (mode_r)
        MODE_ESC: begin
          if (c == CH_U && !last) mode_nxt = MODE_HEX;
          else                    mode_nxt = MODE_PLAIN;
        end
        MODE_HEX: begin
          if (hv.ok && cnt_r == 2'd3) mode_nxt = MODE_PLAIN;
          else if (hv.ok && !last)    mode_nxt = MODE_HEX;
          else if (new_esc)           mode_nxt = MODE_ESC;
          else                        mode_nxt = MODE_PLAIN;
        end
        default: begin
          mode_nxt = new_esc ? MODE_ESC : MODE_PLAIN;
        end
      endcase
      if (last) mode_nxt = MODE_PLAIN;
    end
  end

  // output bytes and digit collection
  always_comb begin
    cmd.bytes = '0;
    cmd.n     = '0;
    cmd.last  = last;
    cnt_nxt   = cnt_r;
    cp_nxt    = cp_r;
    held_nxt  = held_r;
    unique case (mode_r)
      MODE_ESC: begin
        case (c)
          CH_N:     begin cmd.bytes[0] = CH_LF;    cmd.n = NCNT_W'(1); end
          CH_R:     begin cmd.bytes[0] = CH_CR;    cmd.n = NCNT_W'(1); end
          CH_QUOTE: begin cmd.bytes[0] = CH_QUOTE; cmd.n = NCNT_W'(1); end
          CH_BSL:   begin cmd.bytes[0] = CH_BSL;   cmd.n = NCNT_W'(1); end
          default: begin
            if (c == CH_U && !last) begin
              cnt_nxt = '0;
              cp_nxt  = '0;
            end else begin
              cmd.bytes[0] = CH_BSL;
              cmd.bytes[1] = c;
              cmd.n        = NCNT_W'(2);
            end
          end
        endcase
      end
      MODE_HEX: begin
        if (hv.ok && cnt_r == 2'd3) begin
          cmd.bytes[2:0] = u.bytes;
          cmd.n          = {1'b0, u.n};
          cnt_nxt        = '0;
        end else if (hv.ok && !last) begin
          held_nxt[cnt_r] = c;
          cp_nxt          = cp_shift;
          cnt_nxt         = cnt_r + 2'd1;
        end else begin
          // broken or cut-off escape: replay the prefix as plain text
          cmd.bytes[0]   = CH_BSL;
          cmd.bytes[1]   = CH_U;
          cmd.bytes[4:2] = held_r;
          if (!new_esc) begin
            cmd.bytes[pos] = c;
            cmd.n          = pos + NCNT_W'(1);
          end else begin
            cmd.n = pos;
          end
          cnt_nxt = '0;
        end
      end
      default: begin
        if (!new_esc) begin
          cmd.bytes[0] = c;
          cmd.n        = NCNT_W'(1);
        end
      end
    endcase
    if (last) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      if (accept) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cp_r   <= cp_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Small queue of decoded byte groups between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jsu_pkg::cmd_t wr_data,
  output logic               wr_ready,
  output logic               rd_valid,
  output jsu_pkg::cmd_t      rd_data,
  input  wire logic          pop
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// File: hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Walks the byte group at the head of the queue and sends one byte per beat
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire jsu_pkg::cmd_t head,
  output logic               pop,
  jsu_out_if.source          out_ch
);
  import jsu_pkg::*;

  logic [NCNT_W-1:0] idx_r, idx_nxt;
  logic              ov_r, ov_nxt;
  byte_t             ob_r;
  logic              ol_r;
  logic              load;
  logic              final_beat;

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.out_last = ol_r;

  assign load       = q_valid && (!ov_r || out_ch.ready);
  assign final_beat = (idx_r == head.n - NCNT_W'(1));
  assign pop        = load && final_beat;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      idx_nxt = final_beat ? '0 : idx_r + NCNT_W'(1);
      ov_nxt  = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= head.bytes[idx_r];
      ol_r <= head.last && final_beat;
    end
  end

endmodule

`default_nettype wire
